// ===== design/line_draw_color_interp_core_macros.svh =====
// Assertion macros shared by the line draw color interpolation core.
`ifndef LINE_DRAW_COLOR_INTERP_CORE_MACROS_SVH
`define LINE_DRAW_COLOR_INTERP_CORE_MACROS_SVH

// Checked property, masked while reset is asserted
`define LDCI_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, live during reset as well
`define LDCI_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ldci_pkg.sv =====
// Shared types and constants for the line draw color interpolation core.
package ldci_pkg;

    localparam int SCREEN_SIZE_DEF     = 1024;
    localparam int COLOR_FRAC_BITS_DEF = 16;

    // Input beat kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Slope cases
    localparam logic [2:0] CASE_VERT        = 3'd0;
    localparam logic [2:0] CASE_SHALLOW_POS = 3'd1;
    localparam logic [2:0] CASE_STEEP_POS   = 3'd2;
    localparam logic [2:0] CASE_SHALLOW_NEG = 3'd3;
    localparam logic [2:0] CASE_STEEP_NEG   = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch segment setup, start color divides
        logic adv;         // step one pixel
        logic emit_first;  // store color steps, emit first pixel
    } ldci_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // output register can take a beat this cycle
        logic div_done;    // color step quotients ready
    } ldci_stat_t;

endpackage

// ===== design/ldci_div.sv =====
// Three-lane restoring divider, one quotient bit per cycle.
module ldci_div #(
    parameter int NW = 25,
    parameter int CW = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2:0][NW-1:0]   num,
    input  logic [CW-1:0]        den,
    output logic [2:0][NW-1:0]   quot,
    output logic                 done
);

    localparam int CNTW = $clog2(NW + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]       den_reg;
    logic [2:0][NW-1:0]  q_reg, q_next;
    logic [2:0][CW-1:0]  rem_reg, rem_next;
    logic [2:0][CW:0]    trial;

    // One restoring step per lane
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        for (int l = 0; l < 3; l++)
        begin
            trial[l] = {rem_reg[l], q_reg[l][NW-1]};
        end
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            q_next    = num;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (trial[l] >= {1'b0, den_reg})
                begin
                    rem_next[l] = CW'(trial[l] - {1'b0, den_reg});
                    q_next[l]   = {q_reg[l][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[l][CW-1:0];
                    q_next[l]   = {q_reg[l][NW-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

// ===== design/ldci_datapath.sv =====
// Segment setup, midpoint stepping, color accumulation and output register.
module ldci_datapath #(
    parameter int SCREEN_SIZE     = ldci_pkg::SCREEN_SIZE_DEF,
    parameter int COLOR_FRAC_BITS = ldci_pkg::COLOR_FRAC_BITS_DEF,
    parameter int CW              = $clog2(SCREEN_SIZE)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ldci_pkg::ldci_cmd_t  cmd,
    output ldci_pkg::ldci_stat_t st,
    input  logic [CW-1:0]        x_start,
    input  logic [CW-1:0]        y_start,
    input  logic [CW-1:0]        x_end,
    input  logic [CW-1:0]        y_end,
    input  logic [2:0][7:0]      color_start,
    input  logic [2:0][7:0]      color_end,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [CW-1:0]        pixel_x,
    output logic [CW-1:0]        pixel_y,
    output logic [2:0][7:0]      color,
    output logic                 last_pixel
);

    localparam int F  = COLOR_FRAC_BITS;
    localparam int DW = CW + 4;
    localparam int AW = F + 10;
    localparam int SW = F + 9;
    localparam int NW = ((8 + F > CW) ? 8 + F : CW) + 1;

    // Accumulator to 8-bit color: clamp at 0, round, clamp at 255
    function automatic logic [7:0] color_out(input logic signed [AW-1:0] acc);
        logic [AW-1:0] sum;
        logic [AW-F-1:0] v;
        if (acc < 0)
        begin
            return 8'd0;
        end
        sum = AW'(acc) + AW'(1 << (F - 1));
        v   = sum[AW-1:F];
        if (v > (AW-F)'(255))
        begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    // Segment state
    logic                      active_reg;
    logic [2:0]                case_reg;
    logic [CW-1:0]             col_reg, row_reg, stop_reg;
    logic signed [DW-1:0]      dec_reg, inc_s_reg, inc_d_reg;
    logic signed [2:0][AW-1:0] acc_reg;
    logic signed [2:0][SW-1:0] step_reg;
    logic [2:0]                neg_reg;
    logic                      lenz_reg;

    // Output register
    logic                      ovalid_reg;
    logic [CW-1:0]             ox_reg, oy_reg;
    logic [2:0][7:0]           ocol_reg;
    logic                      olast_reg;

    // Setup terms
    logic                      swap;
    logic [CW-1:0]             xa, ya, xb, yb;
    logic [2:0][7:0]           ca, cb;
    logic signed [DW-1:0]      dx, dy;
    logic [2:0]                case_new;
    logic [CW-1:0]             len, stop_new;
    logic signed [DW-1:0]      dec_new, inc_s_new, inc_d_new;
    logic [2:0]                neg_new;
    logic [2:0][NW-1:0]        num;
    logic signed [8:0]         diff;
    logic [7:0]                mag;
    logic [2:0][NW-1:0]        quot;
    logic                      div_done;

    // Step terms
    logic                      diag;
    logic signed [DW-1:0]      dec_nx;
    logic [CW-1:0]             col_nx, row_nx;
    logic signed [2:0][AW-1:0] acc_nx;
    logic                      last_nx, last_cur;
    logic [2:0][7:0]           col_cur_c, col_nx_c;

    // Endpoint ordering and slope case selection
    always_comb
    begin
        swap = (x_end == x_start) ? (y_end < y_start) : (x_end < x_start);
        xa = swap ? x_end : x_start;
        ya = swap ? y_end : y_start;
        xb = swap ? x_start : x_end;
        yb = swap ? y_start : y_end;
        ca = swap ? color_end : color_start;
        cb = swap ? color_start : color_end;
        dx = DW'($signed({1'b0, xb})) - DW'($signed({1'b0, xa}));
        dy = DW'($signed({1'b0, yb})) - DW'($signed({1'b0, ya}));
        if (dx == 0)
        begin
            case_new = ldci_pkg::CASE_VERT;
            stop_new = yb;
            len      = dy[CW-1:0];
            dec_new  = '0;
            inc_s_new = '0;
            inc_d_new = '0;
        end
        else if (dy >= 0 && dy <= dx)
        begin
            case_new = ldci_pkg::CASE_SHALLOW_POS;
            stop_new = xb;
            len      = dx[CW-1:0];
            dec_new  = DW'(dx - 2 * dy);
            inc_s_new = DW'(-2 * dy);
            inc_d_new = DW'(2 * (dx - dy));
        end
        else if (dy > dx)
        begin
            case_new = ldci_pkg::CASE_STEEP_POS;
            stop_new = yb;
            len      = dy[CW-1:0];
            dec_new  = DW'(2 * dx - dy);
            inc_s_new = DW'(2 * dx);
            inc_d_new = DW'(2 * (dx - dy));
        end
        else if (dy >= -dx)
        begin
            case_new = ldci_pkg::CASE_SHALLOW_NEG;
            stop_new = xb;
            len      = dx[CW-1:0];
            dec_new  = DW'(-2 * dy - dx);
            inc_s_new = DW'(-2 * dy);
            inc_d_new = DW'(-2 * dy - 2 * dx);
        end
        else
        begin
            case_new = ldci_pkg::CASE_STEEP_NEG;
            stop_new = yb;
            len      = CW'(-dy);
            dec_new  = DW'(-dy - 2 * dx);
            inc_s_new = DW'(-2 * dx);
            inc_d_new = DW'(-2 * dy - 2 * dx);
        end
        // Rounded magnitude numerators for the color steps
        for (int l = 0; l < 3; l++)
        begin
            diff       = $signed({1'b0, cb[l]}) - $signed({1'b0, ca[l]});
            neg_new[l] = diff[8];
            mag        = diff[8] ? 8'(-diff) : diff[7:0];
            num[l]     = (NW'(mag) << F) + NW'(len >> 1);
        end
    end

    ldci_div #(
        .NW (NW),
        .CW (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .num   (num),
        .den   (len),
        .quot  (quot),
        .done  (div_done)
    );

    // Midpoint step from the current pixel
    always_comb
    begin
        diag = 1'b0;
        case (case_reg) inside
            ldci_pkg::CASE_SHALLOW_POS, ldci_pkg::CASE_STEEP_NEG: diag = (dec_reg < 0);
            ldci_pkg::CASE_STEEP_POS, ldci_pkg::CASE_SHALLOW_NEG: diag = (dec_reg >= 0);
            default: diag = 1'b0;
        endcase
        dec_nx = dec_reg;
        col_nx = col_reg;
        row_nx = row_reg;
        if (case_reg != ldci_pkg::CASE_VERT)
        begin
            dec_nx = dec_reg + (diag ? inc_d_reg : inc_s_reg);
        end
        case (case_reg)
            ldci_pkg::CASE_SHALLOW_POS:
            begin
                col_nx = col_reg + 1'b1;
                row_nx = row_reg + CW'(diag);
            end
            ldci_pkg::CASE_SHALLOW_NEG:
            begin
                col_nx = col_reg + 1'b1;
                row_nx = row_reg - CW'(diag);
            end
            ldci_pkg::CASE_STEEP_POS:
            begin
                row_nx = row_reg + 1'b1;
                col_nx = col_reg + CW'(diag);
            end
            ldci_pkg::CASE_STEEP_NEG:
            begin
                row_nx = row_reg - 1'b1;
                col_nx = col_reg + CW'(diag);
            end
            default:
            begin
                row_nx = row_reg + 1'b1;
            end
        endcase
        // Lane selects of a packed array are unsigned, so sign-extend the step explicitly
        for (int l = 0; l < 3; l++)
        begin
            acc_nx[l]    = acc_reg[l] + AW'($signed(step_reg[l]));
            col_cur_c[l] = color_out(acc_reg[l]);
            col_nx_c[l]  = color_out(acc_nx[l]);
        end
        if (case_reg == ldci_pkg::CASE_SHALLOW_POS || case_reg == ldci_pkg::CASE_SHALLOW_NEG)
        begin
            last_cur = (col_reg == stop_reg);
            last_nx  = (col_nx == stop_reg);
        end
        else
        begin
            last_cur = (row_reg == stop_reg);
            last_nx  = (row_nx == stop_reg);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                active_reg <= 1'b0;
            end
            else if (cmd.emit_first)
            begin
                active_reg <= !last_cur;
            end
            else if (cmd.adv && active_reg)
            begin
                active_reg <= !last_nx;
            end
            if (cmd.emit_first || (cmd.adv && active_reg))
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Segment and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            case_reg  <= case_new;
            col_reg   <= xa;
            row_reg   <= ya;
            stop_reg  <= stop_new;
            dec_reg   <= dec_new;
            inc_s_reg <= inc_s_new;
            inc_d_reg <= inc_d_new;
            neg_reg   <= neg_new;
            lenz_reg  <= (len == '0);
            for (int l = 0; l < 3; l++)
            begin
                acc_reg[l] <= AW'(ca[l]) << F;
            end
        end
        else if (cmd.emit_first)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (lenz_reg)
                begin
                    step_reg[l] <= '0;
                end
                else if (neg_reg[l])
                begin
                    step_reg[l] <= -$signed({1'b0, quot[l][F+7:0]});
                end
                else
                begin
                    step_reg[l] <= $signed({1'b0, quot[l][F+7:0]});
                end
            end
            ox_reg    <= col_reg;
            oy_reg    <= row_reg;
            ocol_reg  <= col_cur_c;
            olast_reg <= last_cur;
        end
        else if (cmd.adv && active_reg)
        begin
            col_reg   <= col_nx;
            row_reg   <= row_nx;
            dec_reg   <= dec_nx;
            acc_reg   <= acc_nx;
            ox_reg    <= col_nx;
            oy_reg    <= row_nx;
            ocol_reg  <= col_nx_c;
            olast_reg <= last_nx;
        end
    end

    assign st.out_free = !ovalid_reg || out_ready;
    assign st.div_done = div_done;
    assign out_valid   = ovalid_reg;
    assign pixel_x     = ox_reg;
    assign pixel_y     = oy_reg;
    assign color       = ocol_reg;
    assign last_pixel  = olast_reg;

endmodule

// ===== design/ldci_ctrl.sv =====
// Controller: input acceptance and sequencing of the segment setup.
`include "line_draw_color_interp_core_macros.svh"

module ldci_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_kind,
    output logic                 in_ready,
    input  ldci_pkg::ldci_stat_t st,
    output ldci_pkg::ldci_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       fire;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        fire           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = st.out_free;
                fire     = in_valid && st.out_free;
                if (fire && in_kind == ldci_pkg::KIND_START)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
                else if (fire)
                begin
                    cmd.adv = 1'b1;
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_first = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LDCI_CHECK(a_div_to_emit, (state_reg == S_DIV && st.div_done) |=> (state_reg == S_EMIT), "divide done did not lead to first pixel")
    `LDCI_CHECK(a_emit_has_room, cmd.emit_first |-> st.out_free, "first pixel emitted into a full output register")
    `LDCI_CHECK(a_busy_blocks, (state_reg != S_IDLE) |-> !in_ready, "input accepted during segment setup")
    `LDCI_CHECK_ALWAYS(a_cmd_excl, !(cmd.load && cmd.adv) && !(cmd.load && cmd.emit_first), "conflicting datapath commands")

endmodule

// ===== design/line_draw_color_interp_core.sv =====
// Top level of the line draw color interpolation core.
// Midpoint line rasterizer with per-pixel RGB interpolation. A start beat (tuser 0)
// carries both endpoints and colors and produces the segment's first pixel after
// the three color steps are divided out: the serial divider gives one quotient bit
// per cycle, and the first pixel is registered once the controller sees the divide
// done and the output register is free. The input is ready again once the controller
// is back in idle and the output register can take a beat. Each advance beat (tuser 1)
// produces the next pixel in the cycle after it is accepted; an advance with no
// open segment produces nothing. The segment's final pixel carries tlast. A start
// beat abandons any open segment. Coordinates wrap at SCREEN_SIZE, a power of two.
module line_draw_color_interp_core #(
    parameter int SCREEN_SIZE     = ldci_pkg::SCREEN_SIZE_DEF,
    parameter int COLOR_FRAC_BITS = ldci_pkg::COLOR_FRAC_BITS_DEF,
    parameter int CW              = $clog2(SCREEN_SIZE),
    parameter int IN_DW           = ((4 * CW + 48 + 7) / 8) * 8,
    parameter int OUT_DW          = ((2 * CW + 24 + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // x_start, y_start, x_end, y_end, start_red, start_green, start_blue,
    // end_red, end_green, end_blue
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // kind
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // pixel_x, pixel_y, red, green, blue
    output logic [OUT_DW-1:0] m_axis_tdata,
    output logic              m_axis_tlast
);

    ldci_pkg::ldci_cmd_t  cmd;
    ldci_pkg::ldci_stat_t st;
    logic [CW-1:0]        pixel_x, pixel_y;
    logic [2:0][7:0]      color;
    logic [2:0][7:0]      color_start, color_end;

    // Input color unpacking
    assign color_start = {s_axis_tdata[4*CW+23:4*CW+16], s_axis_tdata[4*CW+15:4*CW+8],
                          s_axis_tdata[4*CW+7:4*CW]};
    assign color_end   = {s_axis_tdata[4*CW+47:4*CW+40], s_axis_tdata[4*CW+39:4*CW+32],
                          s_axis_tdata[4*CW+31:4*CW+24]};

    ldci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ldci_datapath #(
        .SCREEN_SIZE     (SCREEN_SIZE),
        .COLOR_FRAC_BITS (COLOR_FRAC_BITS),
        .CW              (CW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .x_start     (s_axis_tdata[CW-1:0]),
        .y_start     (s_axis_tdata[2*CW-1:CW]),
        .x_end       (s_axis_tdata[3*CW-1:2*CW]),
        .y_end       (s_axis_tdata[4*CW-1:3*CW]),
        .color_start (color_start),
        .color_end   (color_end),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .color       (color),
        .last_pixel  (m_axis_tlast)
    );

    // Output packing, zero fill to whole bytes
    assign m_axis_tdata = OUT_DW'({color[2], color[1], color[0], pixel_y, pixel_x});

endmodule
